// ===== design/block_float_quantizer_assert.svh =====
// Assertion macros for the block float quantizer
`ifndef BLOCK_FLOAT_QUANTIZER_ASSERT_SVH
`define BLOCK_FLOAT_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define BFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BFQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/bfq_pkg.sv =====
// ----------------------------------------------------------------------------
// bfq_pkg
// Shared types and constants of the block float quantizer.
// ----------------------------------------------------------------------------
package bfq_pkg;

    localparam int MaxBlock  = 32;
    localparam int AddrW     = $clog2(MaxBlock);
    localparam int CntW      = $clog2(MaxBlock + 1);

    localparam logic [30:0] TinyBits = 31'h2EDBE6FF;
    localparam logic [30:0] InfBits  = 31'h7F800000;

    localparam logic CfgBlockLength  = 1'b0;
    localparam logic CfgMantissaBits = 1'b1;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [CntW-1:0]    count;
        logic signed [7:0]  sexp;
        logic [3:0]         mbits;
    } t_emit_ctl;

endpackage

// ===== design/bfq_ram.sv =====
// ----------------------------------------------------------------------------
// bfq_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module bfq_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // read data holds until the next read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== design/bfq_quant.sv =====
// ----------------------------------------------------------------------------
// bfq_quant
// Turns one stored element into a signed mantissa, one element per cycle.
// ----------------------------------------------------------------------------
module bfq_quant (
    input  logic [31:0]       i_bits,
    input  logic signed [7:0] i_sexp,
    input  logic [3:0]        i_mbits,
    output logic [7:0]        o_mant
);
    logic [30:0] a;
    logic [7:0]  ebits;
    logic [23:0] mant;
    logic signed [10:0] s;
    logic [4:0]  n;
    logic [7:0]  limit;
    logic [24:0] rnd;
    logic [31:0] shl;
    logic [7:0]  mag;

    always_comb begin
        a     = i_bits[30:0];
        ebits = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        mant  = {(a[30:23] != 8'd0), a[22:0]};
        limit = 8'((9'd1 << (i_mbits - 4'd1)) - 9'd1);
        s     = 11'(signed'({3'b0, ebits})) - 11'sd151 + 11'(signed'({7'b0, i_mbits}))
                - 11'(i_sexp);
        n     = 5'((-s) > 11'sd25 ? 11'sd25 : -s);
        rnd   = 25'd0;
        shl   = 32'd0;
        mag   = 8'd0;
        if (a > bfq_pkg::InfBits || i_sexp == -8'sd127) begin
            mag = 8'd0;
        end else if (a == bfq_pkg::InfBits) begin
            mag = limit;
        end else if (mant == 24'd0) begin
            mag = 8'd0;
        end else if (s >= 0) begin
            shl = {8'd0, mant} << s[3:0];
            mag = (s > 11'sd8 || shl > {24'd0, limit}) ? limit : shl[7:0];
        end else if (-s > 11'sd25) begin
            mag = 8'd0;
        end else begin
            rnd = ({1'b0, mant} + (25'd1 << (n - 5'd1))) >> n;
            mag = (rnd > {17'd0, limit}) ? limit : rnd[7:0];
        end
        o_mant = i_bits[31] ? (8'd0 - mag) : mag;
    end
endmodule

// ===== design/block_float_quantizer.sv =====
// A block's first result passes the FSM state, the RAM read register and the output register.
// Elements load at 1 per cycle, then emit at 1 per cycle while the output is not stalled;
// input reopens once the block's last element enters the output register.
// The block buffer's single read port paces the emit phase; input stalls during it.
// Reset (synchronous, active low) clears fill count, maximum, FSM and output valid, and sets config regs to 32 and 8.
// Buffer contents are not cleared; only entries written in the current block are read.
// ----------------------------------------------------------------------------
// block_float_quantizer
// Buffers FP32 samples per block, then emits shared-exponent mantissas.
// ----------------------------------------------------------------------------
`include "block_float_quantizer_assert.svh"
module block_float_quantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
    input  logic        s_axis_tlast,   // end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] mantissa, [15:8] block_exp
    output logic        m_axis_tlast,   // block_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    localparam int AW = bfq_pkg::AddrW;
    localparam int CW = bfq_pkg::CntW;

    bfq_pkg::t_state   r_state, n_state;
    logic [5:0]        r_blen;
    logic [3:0]        r_mbits;
    logic [CW-1:0]     r_fill, n_fill;
    logic [30:0]       r_max, n_max;
    logic [CW-1:0]     r_rd, n_rd;
    logic              r_pend, n_pend;     // RAM data valid for r_rd-1
    logic              r_plast, n_plast;
    logic              r_ov, n_ov;
    logic [15:0]       r_od, n_od;
    logic              r_ol, n_ol;
    logic signed [7:0] r_sexp, n_sexp;
    logic [3:0]        r_mb_e, n_mb_e;

    logic [CW-1:0]     len;
    logic [3:0]        mbe;
    logic              in_acc, out_free, rd_go;
    logic [31:0]       rdata;
    logic [7:0]        qm;
    logic [CW-1:0]     fill_inc;
    logic [30:0]       a;
    logic [8:0]        e;

    always_comb begin
        if (r_blen == 6'd0)                    len = CW'(1);
        else if (r_blen > 6'(bfq_pkg::MaxBlock)) len = CW'(bfq_pkg::MaxBlock);
        else                                   len = CW'(r_blen);
        if (r_mbits < 4'd2)      mbe = 4'd2;
        else if (r_mbits > 4'd8) mbe = 4'd8;
        else                     mbe = r_mbits;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == bfq_pkg::ST_FILL);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign fill_inc      = r_fill + CW'(1);
    assign a             = s_axis_tdata[30:0];
    assign out_free      = !r_ov || m_axis_tready;
    // read issues only when the pending word has room to move into the output
    assign rd_go         = (r_state == bfq_pkg::ST_EMIT) && (r_rd != r_fill)
                           && (!r_pend || out_free);

    bfq_ram #(.Width(32), .Depth(bfq_pkg::MaxBlock)) u_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(s_axis_tdata),
        .i_re   (rd_go),
        .i_raddr(r_rd[AW-1:0]),
        .o_rdata(rdata)
    );

    bfq_quant u_quant (
        .i_bits (rdata),
        .i_sexp (r_sexp),
        .i_mbits(r_mb_e),
        .o_mant (qm)
    );

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_max   = r_max;
        n_rd    = r_rd;
        n_sexp  = r_sexp;
        n_mb_e  = r_mb_e;
        e       = 9'd0;
        unique case (r_state)
            bfq_pkg::ST_FILL: begin
                if (in_acc) begin
                    n_fill = fill_inc;
                    if (a <= bfq_pkg::InfBits && a > r_max) n_max = a;
                    if (s_axis_tlast || fill_inc >= len) begin
                        n_state = bfq_pkg::ST_EMIT;
                        n_rd    = CW'(0);
                        n_mb_e  = mbe;
                        e = {1'b0, n_max[30:23]} + 9'd1;
                        if (n_max < bfq_pkg::TinyBits) n_sexp = -8'sd127;
                        else if (e > 9'd254)           n_sexp = 8'sd127;
                        else                           n_sexp = 8'(e - 9'd127);
                    end
                end
            end
            bfq_pkg::ST_EMIT: begin
                if (rd_go) n_rd = r_rd + CW'(1);
                if (r_pend && out_free && r_plast) begin
                    n_state = bfq_pkg::ST_FILL;
                    n_fill  = CW'(0);
                    n_max   = 31'd0;
                end
            end
            default: n_state = bfq_pkg::ST_FILL;
        endcase
    end

    always_comb begin
        n_pend  = r_pend;
        n_plast = r_plast;
        n_ov    = r_ov;
        n_od    = r_od;
        n_ol    = r_ol;
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        if (r_pend && out_free) begin
            n_ov   = 1'b1;
            n_od   = {r_sexp, qm};
            n_ol   = r_plast;
            n_pend = 1'b0;
        end
        if (rd_go) begin
            n_pend  = 1'b1;
            n_plast = (r_rd + CW'(1) == r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfq_pkg::ST_FILL;
            r_blen  <= 6'd32;
            r_mbits <= 4'd8;
            r_fill  <= '0;
            r_max   <= '0;
            r_rd    <= '0;
            r_pend  <= 1'b0;
            r_plast <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == bfq_pkg::CfgBlockLength) r_blen  <= i_cfg_data;
                else                                        r_mbits <= i_cfg_data[3:0];
            end
            r_state <= n_state;
            r_fill  <= n_fill;
            r_max   <= n_max;
            r_rd    <= n_rd;
            r_pend  <= n_pend;
            r_plast <= n_plast;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od   <= n_od;
        r_ol   <= n_ol;
        r_sexp <= n_sexp;
        r_mb_e <= n_mb_e;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;

    `BFQ_ASSERT_IMP(a_rd_le_fill, i_clk, i_rst_n, r_state == bfq_pkg::ST_EMIT, r_rd <= r_fill)
    `BFQ_ASSERT_IMP(a_no_in_emit, i_clk, i_rst_n, r_state == bfq_pkg::ST_EMIT, !in_acc)
    `BFQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !m_axis_tready, r_ov && $stable(r_od))
    `BFQ_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= CW'(bfq_pkg::MaxBlock))
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// block_float_quantizer testbench
// Feeds FP32 samples in blocks with random content, predicts mantissas and
// shared exponents per closed block, and checks every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] bits;
        logic        eod;
    } t_sample;

    typedef struct packed {
        logic [7:0] mant;
        logic [7:0] sexp;
        logic       last;
    } t_quant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [5:0]  i_cfg_data = '0;

    block_float_quantizer uut (.*);

    always #1 i_clk = ~i_clk;

    t_sample     sample_queue[$];
    t_quant      quant_queue[$];
    logic [31:0] block_buf[bfq_pkg::MaxBlock];
    int          fill_cnt = 0;
    logic [30:0] max_mag = '0;
    int          blk_len = 32;
    int          mbits = 8;
    int          errors = 0;
    int          idle_cnt = 0;
    bit          calm = 1'b0;
    int          hold_off = 0;
    int          src_gap = 0;
    int          sink_gap = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    function automatic logic [7:0] quant_one(input logic [31:0] b, input int se, input int mb);
        logic [30:0] a;
        logic [63:0] mag, lim, m;
        int          e, s, n;
        begin
            a = b[30:0];
            lim = (64'd1 << (mb - 1)) - 1;
            if (a > bfq_pkg::InfBits || se == -127) return 8'd0;
            if (a == bfq_pkg::InfBits) mag = lim;
            else begin
                e = a[30:23];
                m = {41'd0, a[22:0]};
                if (e != 0) m[23] = 1'b1;
                else e = 1;
                s = e - 150 + mb - 1 - se;
                if (m == 0) mag = 0;
                else if (s >= 0) mag = (s > 8) ? lim : (m << s);
                else if (-s > 25) mag = 0;
                else begin
                    n = -s;
                    mag = (m + (64'd1 << (n - 1))) >> n;
                end
                if (mag > lim) mag = lim;
            end
            return b[31] ? 8'(-mag) : 8'(mag);
        end
    endfunction

    task automatic predict_block(input t_sample smp);
        int     se;
        t_quant q;
        begin
            block_buf[fill_cnt] = smp.bits;
            fill_cnt++;
            if (smp.bits[30:0] <= bfq_pkg::InfBits && smp.bits[30:0] > max_mag)
                max_mag = smp.bits[30:0];
            if (smp.eod || fill_cnt >= blk_len) begin
                if (max_mag < bfq_pkg::TinyBits) se = -127;
                else begin
                    se = int'(max_mag[30:23]) - 126;
                    if (se > 127) se = 127;
                end
                for (int i = 0; i < fill_cnt; i++) begin
                    q.mant = quant_one(block_buf[i], se, mbits);
                    q.sexp = 8'(se);
                    q.last = (i == fill_cnt - 1);
                    quant_queue.push_back(q);
                end
                fill_cnt = 0;
                max_mag = '0;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_block({s_axis_tdata, s_axis_tlast});
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    {s_axis_tdata, s_axis_tlast} <= sample_queue.pop_front();
                    if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 4);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_quant q;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (quant_queue.size() == 0) begin
                    report("unexpected beat", 32'(m_axis_tdata), 32'd0);
                end else begin
                    q = quant_queue.pop_front();
                    if (m_axis_tdata[7:0] !== q.mant)
                        report("mantissa", 32'(m_axis_tdata[7:0]), 32'(q.mant));
                    if (m_axis_tdata[15:8] !== q.sexp)
                        report("block_exp", 32'(m_axis_tdata[15:8]), 32'(q.sexp));
                    if (m_axis_tlast !== q.last)
                        report("block_last", 32'(m_axis_tlast), 32'(q.last));
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 4);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 5000) begin
            $display("** block_float_quantizer: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] rand_float();
        logic [31:0] b;
        begin
            b = $urandom;
            case ($urandom_range(0, 9))
                0: b[30:0] = 31'd0;
                1: b[30:0] = bfq_pkg::InfBits;
                2: b[30:0] = bfq_pkg::InfBits | 31'($urandom_range(1, 100));
                3: b[30:23] = 8'd0;
                4: b[30:23] = 8'hFE;
                5: b[30:0] = bfq_pkg::TinyBits + 31'($urandom_range(0, 2)) - 31'd1;
                default: b[30:23] = 8'($urandom_range(100, 150));
            endcase
            return b;
        end
    endfunction

    task automatic wait_drained();
        while (sample_queue.size() > 0 || s_axis_tvalid || quant_queue.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] val);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            i_cfg_valid <= 1'b0;
            if (idx == bfq_pkg::CfgBlockLength)
                blk_len = (val == 0) ? 1 :
                          (val > bfq_pkg::MaxBlock ? bfq_pkg::MaxBlock : val);
            else
                mbits = (val[3:0] < 2) ? 2 : (val[3:0] > 8 ? 8 : val[3:0]);
        end
    endtask

    task automatic push_random(input int cnt);
        int left;
        begin
            left = cnt;
            while (left > 0) begin
                sample_queue.push_back({rand_float(), 1'($urandom_range(0, 11) == 0)});
                left--;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes at reset config (len 32, 8 bits), closed early
        sample_queue.push_back({32'h3F800000, 1'b0});
        sample_queue.push_back({32'hBF800000, 1'b0});
        sample_queue.push_back({32'h7F800000, 1'b0});
        sample_queue.push_back({32'hFF800000, 1'b0});
        sample_queue.push_back({32'h7FC00001, 1'b0});
        sample_queue.push_back({32'h80000000, 1'b0});
        sample_queue.push_back({32'h00000001, 1'b0});
        sample_queue.push_back({32'hFFFFFFFF, 1'b1});
        sample_queue.push_back({32'h7F7FFFFF, 1'b0});
        sample_queue.push_back({32'h3FC00000, 1'b1});
        sample_queue.push_back({32'h00000000, 1'b0});
        sample_queue.push_back({32'h80000000, 1'b1});
        sample_queue.push_back({32'h2EDBE6FE, 1'b1});
        sample_queue.push_back({32'h2EDBE6FF, 1'b1});
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd0);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd0);
        push_random(6);
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd63);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd15);
        push_random(40);
        // long receiver stall while the sender keeps offering
        hold_off = 300;
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd5);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd2);
        push_random(80);
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd32);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd8);
        push_random(100);
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd3);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd5);
        push_random(90);
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd1);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd7);
        push_random(40);
        wait_drained();
        write_reg(bfq_pkg::CfgBlockLength, 6'd8);
        write_reg(bfq_pkg::CfgMantissaBits, 6'd4);
        calm = 1'b1;
        push_random(60);
        sample_queue.push_back({rand_float(), 1'b1});
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && quant_queue.size() == 0)
            $display("** block_float_quantizer: PASSED **");
        else
            $display("** block_float_quantizer: FAILED **");
        $finish;
    end
endmodule

// ===== block_float_quantizer.f =====
+incdir+design
design/bfq_pkg.sv
design/bfq_ram.sv
design/bfq_quant.sv
design/block_float_quantizer.sv
test/testbench.sv
